/* hw/rtl/nfd_to_nfc_byte_stream_macros.svh */
// ---------------------------------------------------------------------------
// nfd_to_nfc_byte_stream assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef NFD_TO_NFC_BYTE_STREAM_MACROS_SVH
`define NFD_TO_NFC_BYTE_STREAM_MACROS_SVH

// condition must hold whenever the antecedent holds
`define NFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the antecedent
`define NFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/nfdnfc_pkg.sv */
// ---------------------------------------------------------------------------
// nfdnfc_pkg
// constants, types and lookup functions for the utf-8 nfd to nfc normalizer
// ---------------------------------------------------------------------------
package nfdnfc_pkg;

  // precomposed lead byte and combining mark prefix
  localparam logic [7:0] LeadC3 = 8'hC3;
  localparam logic [7:0] MarkCC = 8'hCC;

  // most result bytes one input byte can cause
  localparam int unsigned MaxResults = 3;

  // default output queue depth
  localparam int unsigned FifoDepth = 8;

  // held-letter state codes
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldBase = 2'd1;
  localparam logic [1:0] HeldMark = 2'd2;

  // one output queue entry
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       output_end;
  } out_ent_t;

  // candidate base letters a, e, i, n, o, u
  function automatic logic is_base(input logic [7:0] b);
    return (b == 8'h61) || (b == 8'h65) || (b == 8'h69) ||
           (b == 8'h6E) || (b == 8'h6F) || (b == 8'h75);
  endfunction

  // second byte of the precomposed form, zero when no match
  function automatic logic [7:0] compose(input logic [7:0] base, input logic [7:0] mark);
    logic [7:0] r;
    r = 8'h00;
    unique case (base)
      8'h61: r = (mark == 8'h80) ? 8'hA0 : ((mark == 8'h81) ? 8'hA1 : 8'h00);
      8'h65: r = (mark == 8'h80) ? 8'hA8 : ((mark == 8'h81) ? 8'hA9 : 8'h00);
      8'h69: r = (mark == 8'h81) ? 8'hAD : 8'h00;
      8'h6E: r = (mark == 8'h83) ? 8'hB1 : 8'h00;
      8'h6F: r = (mark == 8'h81) ? 8'hB3 : 8'h00;
      8'h75: r = (mark == 8'h81) ? 8'hBA : 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // continuation bytes that follow a leader byte
  function automatic logic [1:0] cont_count(input logic [7:0] b);
    logic [1:0] r;
    if (b[7] == 1'b0) begin
      r = 2'd0;
    end else if ((b & 8'hE0) == 8'hC0) begin
      r = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      r = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      r = 2'd3;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/nfd_to_nfc_byte_stream.sv */
// ---------------------------------------------------------------------------
// nfd_to_nfc_byte_stream
// utf-8 byte stream normalizer composing eight fixed decomposed sequences
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one utf-8 byte per
//   transaction with string_end_i on the last byte of a string. Output
//   channel (out_valid_o / out_ready_i) gives one normalized byte per
//   transaction; run_last_o marks the last byte caused by one input byte and
//   output_end_o the last byte of the normalized string.
//   An input byte is held in an input register, then the step logic pushes
//   its zero to three result bytes into an output queue in a single write.
//   Throughput: one input byte per cycle while in_ready_o holds, bounded by
//   the output port at one byte per cycle; the queue (FIFO_DEPTH entries)
//   absorbs three-byte bursts. in_ready_o drops when the queue could not take
//   a full three-byte burst. A base letter, and a 0xCC after it, produce
//   nothing until the next byte or string end decides the match.
//   Reset clears the held letter, the continuation count and the queue.
//   When the receiver stalls, the queue fills and then input stalls too.
// ---------------------------------------------------------------------------
module nfd_to_nfc_byte_stream #(
  parameter int unsigned FIFO_DEPTH = nfdnfc_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       output_end_o
);

  `include "nfd_to_nfc_byte_stream_macros.svh"

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam int unsigned ResN = nfdnfc_pkg::MaxResults;

  // input register
  logic       sv_q, sv_d;
  logic [7:0] st_byte_q;
  logic       st_end_q;

  // normalizer state
  logic [1:0] hc_q, hc_d;
  logic [7:0] hb_q, hb_d;
  logic [1:0] sl_q, sl_d;

  // step results
  logic [7:0] res_byte [ResN];
  logic [1:0] push_n;
  logic [7:0] comp_byte;
  logic       do_start;
  nfdnfc_pkg::out_ent_t res_ent [ResN];

  // output queue
  nfdnfc_pkg::out_ent_t fifo_mem [FIFO_DEPTH];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] widx [ResN];
  logic [SumW-1:0] widx_sum [ResN];
  logic [SumW-1:0] rd_sum;
  logic [SumW-1:0] ready_sum;
  logic            push_en;
  logic            pop;

  // input handshake, ready only while the queue can absorb a full burst
  assign ready_sum  = SumW'(cnt_q) + (sv_q ? SumW'(ResN) : SumW'(0));
  assign in_ready_o = (ready_sum <= SumW'(FIFO_DEPTH - ResN));
  assign sv_d       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_d) begin
      st_byte_q <= in_byte_i;
      st_end_q  <= string_end_i;
    end
  end

  // one step of the normalizer on the registered byte
  assign comp_byte = nfdnfc_pkg::compose(hb_q, st_byte_q);

  always_comb begin
    for (int k = 0; k < ResN; k++) begin
      res_byte[k] = 8'h00;
    end
    push_n   = 2'd0;
    do_start = 1'b0;
    hc_d     = (hc_q == 2'd3) ? nfdnfc_pkg::HeldNone : hc_q;
    hb_d     = hb_q;
    sl_d     = sl_q;

    if (hc_q == nfdnfc_pkg::HeldMark) begin
      if (comp_byte != 8'h00) begin
        res_byte[push_n] = nfdnfc_pkg::LeadC3;
        push_n = push_n + 2'd1;
        res_byte[push_n] = comp_byte;
        push_n = push_n + 2'd1;
      end else begin
        res_byte[push_n] = hb_q;
        push_n = push_n + 2'd1;
        res_byte[push_n] = nfdnfc_pkg::MarkCC;
        push_n = push_n + 2'd1;
        res_byte[push_n] = st_byte_q;
        push_n = push_n + 2'd1;
      end
      hc_d = nfdnfc_pkg::HeldNone;
      hb_d = 8'h00;
      sl_d = 2'd0;
    end else if (hc_q == nfdnfc_pkg::HeldBase) begin
      if (st_byte_q == nfdnfc_pkg::MarkCC) begin
        hc_d = nfdnfc_pkg::HeldMark;
      end else begin
        res_byte[push_n] = hb_q;
        push_n   = push_n + 2'd1;
        hc_d     = nfdnfc_pkg::HeldNone;
        hb_d     = 8'h00;
        do_start = 1'b1;
      end
    end else if (sl_q != 2'd0) begin
      res_byte[push_n] = st_byte_q;
      push_n = push_n + 2'd1;
      sl_d   = sl_q - 2'd1;
    end else begin
      do_start = 1'b1;
    end

    // codepoint start: hold a base letter, else pass the leader
    if (do_start) begin
      if (nfdnfc_pkg::is_base(st_byte_q)) begin
        hc_d = nfdnfc_pkg::HeldBase;
        hb_d = st_byte_q;
      end else begin
        res_byte[push_n] = st_byte_q;
        push_n = push_n + 2'd1;
        sl_d   = nfdnfc_pkg::cont_count(st_byte_q);
      end
    end

    // string end flushes held bytes and returns to reset state
    if (st_end_q) begin
      if (hc_d != nfdnfc_pkg::HeldNone) begin
        res_byte[push_n] = hb_d;
        push_n = push_n + 2'd1;
      end
      if (hc_d == nfdnfc_pkg::HeldMark) begin
        res_byte[push_n] = nfdnfc_pkg::MarkCC;
        push_n = push_n + 2'd1;
      end
      hc_d = nfdnfc_pkg::HeldNone;
      hb_d = 8'h00;
      sl_d = 2'd0;
    end
  end

  // flags go on the last byte of the run
  always_comb begin
    for (int k = 0; k < ResN; k++) begin
      res_ent[k].out_byte   = res_byte[k];
      res_ent[k].run_last   = (push_n == 2'(k + 1));
      res_ent[k].output_end = (push_n == 2'(k + 1)) && st_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= nfdnfc_pkg::HeldNone;
      hb_q <= 8'h00;
      sl_q <= 2'd0;
    end else if (sv_q) begin
      hc_q <= hc_d;
      hb_q <= hb_d;
      sl_q <= sl_d;
    end
  end

  // queue write slots with wrap
  always_comb begin
    for (int k = 0; k < ResN; k++) begin
      widx_sum[k] = SumW'(wr_ptr_q) + SumW'(k);
      if (widx_sum[k] >= SumW'(FIFO_DEPTH)) begin
        widx_sum[k] = widx_sum[k] - SumW'(FIFO_DEPTH);
      end
      widx[k] = widx_sum[k][PtrW-1:0];
    end
  end

  assign push_en = sv_q && (push_n != 2'd0);
  assign pop     = out_valid_o && out_ready_i;

  // pointer and fill count update
  always_comb begin
    rd_sum = SumW'(rd_ptr_q) + SumW'(pop);
    if (rd_sum >= SumW'(FIFO_DEPTH)) begin
      rd_sum = rd_sum - SumW'(FIFO_DEPTH);
    end
    rd_ptr_d = rd_sum[PtrW-1:0];
    wr_ptr_d = push_en ? widx[0] : wr_ptr_q;
    if (push_en) begin
      if (push_n == 2'd1) begin
        wr_ptr_d = widx[1];
      end else if (push_n == 2'd2) begin
        wr_ptr_d = widx[2];
      end else begin
        wr_ptr_d = (widx[2] == PtrW'(FIFO_DEPTH - 1)) ? '0 : widx[2] + PtrW'(1);
      end
    end
    cnt_d = cnt_q + (sv_q ? CntW'(push_n) : CntW'(0)) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      for (int k = 0; k < ResN; k++) begin
        if (push_n > 2'(k)) begin
          fifo_mem[widx[k]] <= res_ent[k];
        end
      end
    end
  end

  // output port
  assign out_valid_o  = (cnt_q != '0);
  assign out_byte_o   = fifo_mem[rd_ptr_q].out_byte;
  assign run_last_o   = fifo_mem[rd_ptr_q].run_last;
  assign output_end_o = fifo_mem[rd_ptr_q].output_end;

  // checks
  `NFD_ASSERT_IMP(a_room_for_burst, sv_q, (SumW'(cnt_q) + SumW'(ResN)) <= SumW'(FIFO_DEPTH),
    "output queue lacks room for a result burst")
  `NFD_ASSERT_IMP(a_held_state_valid, 1'b1, hc_q != 2'd3, "held count reached unused code")
  `NFD_ASSERT_IMP(a_held_is_base, hc_q != nfdnfc_pkg::HeldNone, nfdnfc_pkg::is_base(hb_q),
    "held letter is not a base letter")
  `NFD_ASSERT_NXT(a_end_clears, sv_q && st_end_q,
    (hc_q == nfdnfc_pkg::HeldNone) && (sl_q == 2'd0), "string end did not clear state")
  `NFD_ASSERT_IMP(a_no_mark_with_skip, hc_q != nfdnfc_pkg::HeldNone, sl_q == 2'd0,
    "letter held inside a multi-byte codepoint")

endmodule
